@@ sv/trade_ohlc_bar_builder_top_defines.svh @@
// assertion macros used by tob_back
// clocked on aclk, disabled while aresetn is low
`ifndef TRADE_OHLC_BAR_BUILDER_TOP_DEFINES_SVH
`define TRADE_OHLC_BAR_BUILDER_TOP_DEFINES_SVH

// same-cycle implication
`define TOB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tob_pkg.sv @@
// widths, defaults and word types for the ohlcv bar builder
// no dependencies; used by every module of the block
package tob_pkg;

    localparam int TS_W    = 64;
    localparam int PRICE_W = 64;
    localparam int QTY_W   = 31;
    localparam int SEC_W   = 35;
    localparam int VOL_W   = 31;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

    // stream words, padded to whole bytes
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 328;

    localparam logic [63:0] NS_PER_BAR_DEF  = 64'd1_000_000_000;
    localparam int          QUEUE_DEPTH_DEF = 4;

    // trade after the bar index is known
    typedef struct packed {
        logic [SEC_W-1:0]          sec;
        logic signed [PRICE_W-1:0] price;
        logic [QTY_W-1:0]          qty;
        logic                      eos;
    } item_t;

    // one finished bar
    typedef struct packed {
        logic [SEC_W-1:0]          sec;
        logic signed [PRICE_W-1:0] open_px;
        logic signed [PRICE_W-1:0] high_px;
        logic signed [PRICE_W-1:0] low_px;
        logic signed [PRICE_W-1:0] close_px;
        logic [VOL_W-1:0]          vol;
        logic                      last;
    } bar_t;

endpackage

@@ sv/trade_ohlc_bar_builder_top.sv @@
// top level of the one-second ohlcv bar builder
// instantiates tob_front, tob_fifo and tob_back; uses tob_pkg
//
// Takes one trade word per clock while s_tready is high. The bar index
// timestamp / NS_PER_BAR comes from a three-stage multiply by the reciprocal of
// NS_PER_BAR (32 by 32 partial products, then two adder stages), followed by a
// QUEUE_DEPTH-word queue and the bar update, which writes a trade's bars into
// the output queue ahead of m_tvalid. Most trades emit nothing; a trade that
// both closes a bar and flushes emits two words, which leave one per cycle
// while m_tready is high through a two-word output queue. The bar update waits
// while that queue lacks room for a trade's words, and s_tready drops only when
// the trade queue is full and the multiplier's last stage holds a word.
module trade_ohlc_bar_builder_top #(
    parameter logic [63:0] NS_PER_BAR  = tob_pkg::NS_PER_BAR_DEF,
    parameter int          QUEUE_DEPTH = tob_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // timestamp_ns[63:0], price[127:64], quantity[158:128], zero pad
    input  logic [tob_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bar_second[34:0], bar_open[98:35], bar_high[162:99], bar_low[226:163],
    // bar_close[290:227], bar_volume[321:291], zero pad
    output logic [tob_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import tob_pkg::*;

    logic  push, q_full, pop, q_empty;
    item_t push_item, head;

    tob_front #(
        .NS_PER_BAR (NS_PER_BAR)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    tob_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (head),
        .empty     (q_empty)
    );

    tob_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/tob_front.sv @@
// front end: accepts trades and finds the bar index timestamp / NS_PER_BAR
// by a three-stage multiply with the reciprocal of NS_PER_BAR; uses tob_pkg
module tob_front #(
    parameter logic [63:0] NS_PER_BAR = tob_pkg::NS_PER_BAR_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // timestamp_ns[63:0], price[127:64], quantity[158:128], zero pad
    input  logic [tob_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         push,
    output tob_pkg::item_t               push_item,
    input  logic                         q_full
);
    import tob_pkg::*;

    // q = (ts * RECIP) >> (64 + SHIFT) is exact for every 64-bit ts when
    // RECIP = ceil(2^(64 + SHIFT) / NS_PER_BAR) and SHIFT = clog2(NS_PER_BAR)
    localparam int           STAGES    = 3;
    localparam int           SHIFT     = $clog2(NS_PER_BAR);
    localparam int           Q_LSB     = TS_W + SHIFT;
    localparam int           SUM_W     = Q_LSB + SEC_W;
    localparam logic [127:0] DIVISOR   = {64'd0, NS_PER_BAR};
    localparam logic [127:0] RECIP     = ((128'd1 << Q_LSB) + DIVISOR - 128'd1) / DIVISOR;
    localparam logic [31:0]  RECIP_B0  = RECIP[31:0];
    localparam logic [31:0]  RECIP_B1  = RECIP[63:32];
    localparam logic         RECIP_TOP = RECIP[64];

    logic [TS_W-1:0]           in_ts;
    logic signed [PRICE_W-1:0] in_price;
    logic [QTY_W-1:0]          in_qty;
    logic                      adv;

    logic [STAGES-1:0]         vld_reg;
    logic [STAGES-1:0]         eos_reg;
    logic signed [PRICE_W-1:0] price_reg [STAGES];
    logic [QTY_W-1:0]          qty_reg   [STAGES];

    // stage one: 32 by 32 partial products
    logic [63:0]               pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [TS_W-1:0]           ts_reg;
    // stage two: partial sums
    logic [63:0]               lo_reg;
    logic [64:0]               mid_reg, hi_reg;
    // stage three: bar index
    logic [SUM_W-1:0]          prod;
    logic [SEC_W-1:0]          sec_reg;

    assign in_ts    = s_tdata[TS_W-1:0];
    assign in_price = s_tdata[TS_W +: PRICE_W];
    assign in_qty   = s_tdata[TS_W+PRICE_W +: QTY_W];

    // whole pipe holds only when its last word cannot enter the queue
    assign adv      = !(vld_reg[STAGES-1] && q_full);
    assign s_tready = adv;

    // bits above the index are dropped, which wraps it to its low SEC_W bits
    assign prod = SUM_W'({hi_reg, lo_reg}) + (SUM_W'(mid_reg) << 32);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pp00_reg <= {32'd0, in_ts[31:0]}  * {32'd0, RECIP_B0};
            pp01_reg <= {32'd0, in_ts[31:0]}  * {32'd0, RECIP_B1};
            pp10_reg <= {32'd0, in_ts[63:32]} * {32'd0, RECIP_B0};
            pp11_reg <= {32'd0, in_ts[63:32]} * {32'd0, RECIP_B1};
            ts_reg   <= in_ts;

            lo_reg  <= pp00_reg;
            mid_reg <= {1'b0, pp01_reg} + {1'b0, pp10_reg};
            hi_reg  <= {1'b0, pp11_reg} + (RECIP_TOP ? {1'b0, ts_reg} : 65'd0);

            sec_reg <= prod[SUM_W-1 -: SEC_W];

            price_reg[0] <= in_price;
            qty_reg[0]   <= in_qty;
            eos_reg[0]   <= s_tlast;
            for (int k = 1; k < STAGES; k++) begin
                price_reg[k] <= price_reg[k-1];
                qty_reg[k]   <= qty_reg[k-1];
                eos_reg[k]   <= eos_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_tvalid};
        end
    end

    assign push            = adv && vld_reg[STAGES-1];
    assign push_item.sec   = sec_reg;
    assign push_item.price = price_reg[STAGES-1];
    assign push_item.qty   = qty_reg[STAGES-1];
    assign push_item.eos   = eos_reg[STAGES-1];

endmodule

@@ sv/tob_fifo.sv @@
// short queue of classified trades between the divider and the bar state
// register-based, one push and one pop a cycle; uses tob_pkg
module tob_fifo #(
    parameter int DEPTH = tob_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tob_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output tob_pkg::item_t pop_item,
    output logic           empty
);
    import tob_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/tob_back.sv @@
// back end: open bar state, bar emission and a two-word output queue
// uses tob_pkg and the assertion macros header
`include "trade_ohlc_bar_builder_top_defines.svh"

module tob_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tob_pkg::item_t                head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bar_second[34:0], bar_open[98:35], bar_high[162:99], bar_low[226:163],
    // bar_close[290:227], bar_volume[321:291], zero pad
    output logic [tob_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import tob_pkg::*;

    localparam int PAD_W = OUT_DATA_W - (SEC_W + 4 * PRICE_W + VOL_W);

    // open bar
    logic [SEC_W-1:0]          sec_reg,   sec_next;
    logic signed [PRICE_W-1:0] open_reg,  open_next;
    logic signed [PRICE_W-1:0] high_reg,  high_next;
    logic signed [PRICE_W-1:0] low_reg,   low_next;
    logic signed [PRICE_W-1:0] close_reg, close_next;
    logic [VOL_W-1:0]          vol_reg,   vol_next;

    // bar after this trade, before any flush
    logic [SEC_W-1:0]          mid_sec;
    logic signed [PRICE_W-1:0] mid_open, mid_high, mid_low, mid_close;
    logic [VOL_W-1:0]          mid_vol;
    logic [VOL_W:0]            vol_sum;

    logic       no_bar, new_bar, emit_old, emit_flush;
    logic [1:0] nres, free;
    bar_t       old_bar, flush_bar, res0;

    // output queue
    bar_t       out_mem [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       deq;
    bar_t       out_head;

    always_comb begin
        no_bar  = (sec_reg == '0);
        new_bar = !no_bar && (head.sec != sec_reg);
        vol_sum = {1'b0, vol_reg} + {1'b0, head.qty};

        if (no_bar || new_bar) begin
            mid_sec   = head.sec;
            mid_open  = head.price;
            mid_high  = head.price;
            mid_low   = head.price;
            mid_close = head.price;
            mid_vol   = head.qty;
        end else begin
            mid_sec   = sec_reg;
            mid_open  = open_reg;
            mid_high  = (head.price > high_reg) ? head.price : high_reg;
            mid_low   = (head.price < low_reg) ? head.price : low_reg;
            mid_close = head.price;
            mid_vol   = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
        end

        emit_old   = new_bar && (vol_reg != '0);
        emit_flush = head.eos && (mid_sec != '0) && (mid_vol != '0);
        nres       = {1'b0, emit_old} + {1'b0, emit_flush};
        free       = 2'd2 - cnt_reg;
        pop        = !empty && (nres <= free);
    end

    always_comb begin
        old_bar.sec      = sec_reg;
        old_bar.open_px  = open_reg;
        old_bar.high_px  = high_reg;
        old_bar.low_px   = low_reg;
        old_bar.close_px = close_reg;
        old_bar.vol      = vol_reg;
        old_bar.last     = !emit_flush;

        flush_bar.sec      = mid_sec;
        flush_bar.open_px  = mid_open;
        flush_bar.high_px  = mid_high;
        flush_bar.low_px   = mid_low;
        flush_bar.close_px = mid_close;
        flush_bar.vol      = mid_vol;
        flush_bar.last     = 1'b1;

        res0 = emit_old ? old_bar : flush_bar;
    end

    always_comb begin
        sec_next   = sec_reg;
        open_next  = open_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        close_next = close_reg;
        vol_next   = vol_reg;
        if (pop) begin
            if (head.eos) begin
                sec_next   = '0;
                open_next  = '0;
                high_next  = '0;
                low_next   = '0;
                close_next = '0;
                vol_next   = '0;
            end else begin
                sec_next   = mid_sec;
                open_next  = mid_open;
                high_next  = mid_high;
                low_next   = mid_low;
                close_next = mid_close;
                vol_next   = mid_vol;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg   <= '0;
            open_reg  <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
            close_reg <= '0;
            vol_reg   <= '0;
        end else begin
            sec_reg   <= sec_next;
            open_reg  <= open_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            close_reg <= close_next;
            vol_reg   <= vol_next;
        end
    end

    // output queue: up to two words in, one out per cycle while m_tready is high
    assign out_head = out_mem[rp_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign deq      = m_tvalid && m_tready;
    assign m_tdata  = {PAD_W'(0), out_head.vol, out_head.close_px, out_head.low_px,
                       out_head.high_px, out_head.open_px, out_head.sec};
    assign m_tlast  = out_head.last;

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (pop) begin
            wp_next  = wp_reg ^ nres[0];
            cnt_next = cnt_reg + nres;
        end
        if (deq) begin
            rp_next  = ~rp_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (nres != 2'd0)) begin
            out_mem[wp_reg] <= res0;
        end
        if (pop && (nres == 2'd2)) begin
            out_mem[~wp_reg] <= flush_bar;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `TOB_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= 2'd2, "output queue overfilled")
    `TOB_ASSERT_NOW(a_vol_nonzero, m_tvalid, out_head.vol != '0, "zero-volume bar emitted")
    `TOB_ASSERT_NEXT(a_flush_clears, pop && head.eos, sec_reg == '0, "flush left a bar open")
    `TOB_ASSERT_NEXT(a_two_words, pop && (nres == 2'd2), cnt_reg == 2'd2,
        "double emission lost a word")

endmodule
